>>> rtl/assert_macros.svh
// Assertion macros for the hasher RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define SHASH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("shash assertion failed");

// Condition that must never hold.
`define SHASH_NEVER(lbl, expr) \
  `SHASH_ASSERT(lbl, !(expr))

`endif

>>> rtl/shash_pkg.sv
// Package for the SHA-256 stream hasher: initial hash values, round constants,
// core control struct. No dependencies.
`default_nettype none

package shash_pkg;

  localparam int unsigned NumWords  = 8;
  localparam int unsigned NumRounds = 64;

  localparam logic [31:0] InitHash [NumWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundConst [NumRounds] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  typedef struct packed {
    logic load;       // working vars <- chain
    logic step;       // one compression round
    logic fold;       // chain += working vars
    logic shift_out;  // advance chain toward the digest port
    logic reinit;     // chain <- initial hash
  } core_ctl_t;

endpackage

`default_nettype wire

>>> rtl/shash_sched.sv
// Rolling 16-word message schedule window. Bytes shift in big-endian while a
// block is collected; during rounds it shifts out W[t] and appends W[t+16].
`default_nettype none

module shash_sched (
  input  wire logic        clk_i,
  input  wire logic        byte_en_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        step_i,
  output logic      [31:0] w_o
);

  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [31:0] g0, g1, w_new;

  assign g0 = {win_q[1][6:0], win_q[1][31:7]} ^ {win_q[1][17:0], win_q[1][31:18]}
            ^ {3'b000, win_q[1][31:3]};
  assign g1 = {win_q[14][16:0], win_q[14][31:17]} ^ {win_q[14][18:0], win_q[14][31:19]}
            ^ {10'd0, win_q[14][31:10]};
  assign w_new = win_q[0] + g0 + win_q[9] + g1;
  assign w_o = win_q[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    if (byte_en_i) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[15] = {win_q[15][23:0], byte_i};
    end else if (step_i) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      win_q[i] <= win_d[i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/shash_round.sv
// SHA-256 round unit: working variables a..h, one round per step, and the
// chained hash value. Depends on shash_pkg.
`default_nettype none

module shash_round (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire shash_pkg::core_ctl_t ctl_i,
  input  wire logic [5:0]          round_i,
  input  wire logic [31:0]         w_i,
  output logic      [31:0]         digest_o
);

  logic [31:0] chain_q [shash_pkg::NumWords];
  logic [31:0] chain_d [shash_pkg::NumWords];
  logic [31:0] vars_q  [shash_pkg::NumWords];
  logic [31:0] vars_d  [shash_pkg::NumWords];
  logic [31:0] a, e, s0, s1, maj, ch, t1, t2;

  assign a   = vars_q[0];
  assign e   = vars_q[4];
  assign s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign maj = (a & vars_q[1]) ^ (a & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign ch  = (e & vars_q[5]) ^ (~e & vars_q[6]);
  assign t1  = vars_q[7] + s1 + ch + shash_pkg::RoundConst[round_i] + w_i;
  assign t2  = s0 + maj;
  assign digest_o = chain_q[0];

  always_comb begin
    for (int i = 0; i < shash_pkg::NumWords; i++) begin
      vars_d[i]  = vars_q[i];
      chain_d[i] = chain_q[i];
    end
    if (ctl_i.load) begin
      for (int i = 0; i < shash_pkg::NumWords; i++) begin
        vars_d[i] = chain_q[i];
      end
    end else if (ctl_i.step) begin
      for (int i = 1; i < shash_pkg::NumWords; i++) begin
        vars_d[i] = vars_q[i-1];
      end
      vars_d[0] = t1 + t2;
      vars_d[4] = vars_q[3] + t1;
    end
    if (ctl_i.reinit) begin
      for (int i = 0; i < shash_pkg::NumWords; i++) begin
        chain_d[i] = shash_pkg::InitHash[i];
      end
    end else if (ctl_i.fold) begin
      for (int i = 0; i < shash_pkg::NumWords; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end else if (ctl_i.shift_out) begin
      for (int i = 0; i < shash_pkg::NumWords - 1; i++) begin
        chain_d[i] = chain_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < shash_pkg::NumWords; i++) begin
        chain_q[i] <= shash_pkg::InitHash[i];
      end
    end else begin
      for (int i = 0; i < shash_pkg::NumWords; i++) begin
        chain_q[i] <= chain_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < shash_pkg::NumWords; i++) begin
      vars_q[i] <= vars_d[i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher top level: byte intake, padding sequencer, digest output.
// Depends on shash_pkg, shash_sched, shash_round and assert_macros.svh.
//
// Input channel: one message byte per item (message_byte_i, last_byte_i) on
// in_valid_i / in_ready_o. Output channel: eight digest words per message,
// H0 first, on out_valid_o / out_ready_i with word_index_o and last_word_o.
// Bytes are taken one per cycle while a block fills. The 64th byte of a block
// starts 64 compression rounds at one round per cycle in the shared round
// unit, followed by a fold of the result into the chain; in_ready_o is low
// through the rounds and the fold, so no byte is taken while a block compresses.
// After the final byte the sequencer shifts in padding and the bit length at
// one byte per cycle, compresses once or twice more, then presents the digest
// words from a register, one word per accepted output item. A stalled
// receiver simply holds the current word; no input is taken until all eight
// words are delivered. out_valid_o takes longest to rise after the final byte
// when the message length is 56 mod 64. Reset loads the initial hash and
// clears counts.
`default_nettype none
`include "assert_macros.svh"

module sha256_stream_hasher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  message_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] digest_word_o,
  output logic      [2:0]  word_index_o,
  output logic             last_word_o
);

  typedef enum logic [4:0] {
    ST_ABSORB   = 5'b00001,
    ST_PAD      = 5'b00010,
    ST_COMPRESS = 5'b00100,
    ST_FOLD     = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  logic        pad_q, pad_d;
  logic        sent80_q, sent80_d;
  logic        len_q, len_d;
  logic        done_q, done_d;

  logic        in_acc, out_acc, byte_en, len_byte_sel;
  logic [7:0]  byte_val;
  logic [63:0] len_bits;
  logic [31:0] w;
  shash_pkg::core_ctl_t ctl;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign len_bits = {cnt_q, 3'b000};
  assign len_byte_sel = sent80_q && (len_q || (fill_q == 6'd56));

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    cnt_d    = cnt_q;
    round_d  = round_q;
    idx_d    = idx_q;
    pad_d    = pad_q;
    sent80_d = sent80_q;
    len_d    = len_q;
    done_d   = done_q;
    byte_en  = 1'b0;
    byte_val = message_byte_i;
    ctl      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ST_ABSORB: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          byte_en = 1'b1;
          fill_d  = fill_q + 6'd1;
          cnt_d   = cnt_q + 61'd1;
          pad_d   = last_byte_i;
          if (fill_q == 6'd63) begin
            ctl.load = 1'b1;
            round_d  = '0;
            state_d  = ST_COMPRESS;
          end else if (last_byte_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        byte_en = 1'b1;
        fill_d  = fill_q + 6'd1;
        if (!sent80_q) begin
          byte_val = 8'h80;
          sent80_d = 1'b1;
        end else if (len_byte_sel) begin
          byte_val = len_bits[{~fill_q[2:0], 3'b000} +: 8];
          len_d    = 1'b1;
          if (fill_q == 6'd63) begin
            done_d = 1'b1;
          end
        end else begin
          byte_val = 8'h00;
        end
        if (fill_q == 6'd63) begin
          ctl.load = 1'b1;
          round_d  = '0;
          state_d  = ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        ctl.step = 1'b1;
        round_d  = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        if (done_q) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_ABSORB;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          ctl.shift_out = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            ctl.reinit = 1'b1;
            cnt_d    = '0;
            fill_d   = '0;
            pad_d    = 1'b0;
            sent80_d = 1'b0;
            len_d    = 1'b0;
            done_d   = 1'b0;
            state_d  = ST_ABSORB;
          end
        end
      end
      default: begin
        state_d = ST_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_ABSORB;
      fill_q   <= '0;
      cnt_q    <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      pad_q    <= 1'b0;
      sent80_q <= 1'b0;
      len_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      cnt_q    <= cnt_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      pad_q    <= pad_d;
      sent80_q <= sent80_d;
      len_q    <= len_d;
      done_q   <= done_d;
    end
  end

  shash_sched u_sched (
    .clk_i     (clk_i),
    .byte_en_i (byte_en),
    .byte_i    (byte_val),
    .step_i    (ctl.step),
    .w_o       (w)
  );

  shash_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .round_i  (round_q),
    .w_i      (w),
    .digest_o (digest_word_o)
  );

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd7);

  `SHASH_NEVER(a_no_in_out_overlap, in_ready_o && out_valid_o)
  `SHASH_ASSERT(a_fill_starts_rounds, in_acc && (fill_q == 6'd63) |=> state_q == ST_COMPRESS)
  `SHASH_ASSERT(a_rounds_end_fold, (state_q == ST_COMPRESS) && (round_q == 6'd63) |=> state_q == ST_FOLD)
  `SHASH_ASSERT(a_digest_resets, out_acc && last_word_o |=> (state_q == ST_ABSORB) && (cnt_q == '0))

endmodule

`default_nettype wire
